// ----- rtl/core/jmcu_pkg.sv -----
// ----------------------------------------------------------------------------
// jmcu_pkg
// Shared types, codes and arithmetic helpers of the MCU color converter.
// ----------------------------------------------------------------------------
package jmcu_pkg;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_ROW  = 1'b1;

	localparam logic [2:0] BLK_CB = 3'd4;
	localparam logic [2:0] BLK_CR = 3'd5;

	localparam logic [1:0] CFG_H_SAMPLING = 2'd0;
	localparam logic [1:0] CFG_V_SAMPLING = 2'd1;
	localparam logic [1:0] CFG_LINE_STRIDE = 2'd2;

	localparam logic [1:0]  RST_H_SAMPLING  = 2'd2;
	localparam logic [1:0]  RST_V_SAMPLING  = 2'd2;
	localparam logic [11:0] RST_LINE_STRIDE = 12'd16;

	// BT.601 coefficients, signed Q2.16
	localparam logic signed [17:0] K_CR_R = 18'sd91881;
	localparam logic signed [17:0] K_CB_G = -18'sd22554;
	localparam logic signed [17:0] K_CR_G = -18'sd46802;
	localparam logic signed [17:0] K_CB_B = 18'sd116130;
	localparam logic signed [26:0] K_ROUND = 27'sd32768;
	localparam logic signed [8:0]  CHROMA_BIAS = 9'sd128;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic issue;
	} cmd_t;

	typedef struct packed {
		logic row_ok;
		logic last_col;
		logic adv;
	} stat_t;

	function automatic logic signed [10:0] round_delta(input logic signed [26:0] p);
		logic signed [26:0] s;
		s = p + K_ROUND;
		return s[26:16];
	endfunction

	function automatic logic [7:0] clamp8(input logic signed [17:0] v);
		logic [7:0] r;
		if (v < 18'sd0) begin
			r = 8'h00;
		end else if (v > 18'sd255) begin
			r = 8'hFF;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/jmcu_ctrl.sv -----
// ----------------------------------------------------------------------------
// jmcu_ctrl
// Item sequencer: takes load and row items, steps the columns of a row.
// ----------------------------------------------------------------------------
module jmcu_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             kind,
	input  jmcu_pkg::stat_t  stat,
	output jmcu_pkg::cmd_t   cmd
);

	jmcu_pkg::state_t state_q, state_nx;
	logic             xfer;

	assign xfer = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jmcu_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			jmcu_pkg::ST_IDLE: begin
				if (xfer && kind == jmcu_pkg::KIND_ROW && stat.row_ok) begin
					state_nx = jmcu_pkg::ST_RUN;
				end
			end
			jmcu_pkg::ST_RUN: begin
				if (stat.adv && stat.last_col) begin
					state_nx = jmcu_pkg::ST_IDLE;
				end
			end
			default: state_nx = jmcu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd.load  = 1'b0;
		cmd.start = 1'b0;
		cmd.issue = 1'b0;
		unique case (state_q)
			jmcu_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.load  = xfer && kind == jmcu_pkg::KIND_LOAD;
				cmd.start = xfer && kind == jmcu_pkg::KIND_ROW && stat.row_ok;
			end
			jmcu_pkg::ST_RUN: begin
				cmd.issue = stat.adv;
			end
			default: in_ready = 1'b0;
		endcase
	end

endmodule

// ----- rtl/core/jmcu_dp.sv -----
// ----------------------------------------------------------------------------
// jmcu_dp
// Sample stores, pixel addressing and the three-stage color pipeline.
// ----------------------------------------------------------------------------
module jmcu_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data,
	input  logic [2:0]         block_select,
	input  logic [5:0]         sample_index,
	input  logic signed [15:0] sample_value,
	input  logic [3:0]         row_select,
	input  jmcu_pkg::cmd_t     cmd,
	output jmcu_pkg::stat_t    stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        pixel,
	output logic [15:0]        word_offset,
	output logic               last
);

	logic [1:0]  h_q, v_q;
	logic [11:0] stride_q;

	logic        is420_q, h2_q, v2_q;
	logic [3:0]  row_q, col_q;
	logic [15:0] base_q;

	logic [15:0] luma_mem [0:255];
	logic [7:0]  cb_mem [0:63];
	logic [7:0]  cr_mem [0:63];

	logic [7:0]  yaddr;
	logic [5:0]  cidx;
	logic [2:0]  rv, ch;
	logic        h2, v2, adv;

	logic               v_s1, last_s1;
	logic signed [15:0] y_s1;
	logic [7:0]         cb_s1, cr_s1;
	logic [15:0]        off_s1;

	logic               v_s2, last_s2;
	logic signed [15:0] y_s2;
	logic [15:0]        off_s2;
	logic signed [26:0] pr_s2, pgb_s2, pgr_s2, pb_s2;

	logic signed [8:0]  cb_c, cr_c;
	logic signed [26:0] pr, pgb, pgr, pb;
	logic signed [10:0] rd, gdb, gdr, bd;
	logic signed [11:0] gd;
	logic signed [17:0] rs, gs, bs;
	logic [7:0]         r8, g8, b8;

	logic        out_valid_q, last_q;
	logic [15:0] pixel_q, off_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q      <= jmcu_pkg::RST_H_SAMPLING;
			v_q      <= jmcu_pkg::RST_V_SAMPLING;
			stride_q <= jmcu_pkg::RST_LINE_STRIDE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jmcu_pkg::CFG_H_SAMPLING:  h_q      <= cfg_data[1:0];
				jmcu_pkg::CFG_V_SAMPLING:  v_q      <= cfg_data[1:0];
				jmcu_pkg::CFG_LINE_STRIDE: stride_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// factor 3 acts as 2
	assign h2 = h_q[1];
	assign v2 = v_q[1];

	always_comb begin
		stat.row_ok = (h_q != 2'd0) && (v_q != 2'd0) && ((h2 && v2) || !row_select[3]);
		stat.last_col = (col_q == (h2_q ? 4'd15 : 4'd7));
		stat.adv = adv;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			is420_q <= h2 && v2;
			h2_q    <= h2;
			v2_q    <= v2;
			row_q   <= row_select;
			base_q  <= 16'({12'd0, row_select} * {4'd0, stride_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 4'd0;
		end else if (cmd.start) begin
			col_q <= 4'd0;
		end else if (cmd.issue) begin
			col_q <= col_q + 4'd1;
		end
	end

	// pixel addressing
	always_comb begin
		rv = v2_q ? {1'b0, row_q[2:1]} : row_q[2:0];
		ch = h2_q ? col_q[3:1] : col_q[2:0];
		if (is420_q) begin
			yaddr = {row_q[3], col_q[3], row_q[2:0], col_q[2:0]};
			cidx  = {row_q[3:1], col_q[3:1]};
		end else begin
			yaddr = {1'b0, col_q[3], row_q[2:0], col_q[2:0]};
			cidx  = {rv, ch};
		end
	end

	// sample stores
	always_ff @(posedge clk) begin
		if (cmd.load && !block_select[2]) begin
			luma_mem[{block_select[1:0], sample_index}] <= sample_value;
		end
		if (cmd.issue) begin
			y_s1 <= luma_mem[yaddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && block_select == jmcu_pkg::BLK_CB) begin
			cb_mem[sample_index] <= sample_value[7:0];
		end
		if (cmd.issue) begin
			cb_s1 <= cb_mem[cidx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && block_select == jmcu_pkg::BLK_CR) begin
			cr_mem[sample_index] <= sample_value[7:0];
		end
		if (cmd.issue) begin
			cr_s1 <= cr_mem[cidx];
		end
	end

	assign adv = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= cmd.issue;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			off_s1  <= base_q + {12'd0, col_q};
			last_s1 <= stat.last_col;
		end
	end

	// stage 2: chroma products
	assign cb_c = $signed({1'b0, cb_s1}) - jmcu_pkg::CHROMA_BIAS;
	assign cr_c = $signed({1'b0, cr_s1}) - jmcu_pkg::CHROMA_BIAS;
	assign pr   = jmcu_pkg::K_CR_R * cr_c;
	assign pgb  = jmcu_pkg::K_CB_G * cb_c;
	assign pgr  = jmcu_pkg::K_CR_G * cr_c;
	assign pb   = jmcu_pkg::K_CB_B * cb_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s2    <= y_s1;
			off_s2  <= off_s1;
			last_s2 <= last_s1;
			pr_s2   <= pr;
			pgb_s2  <= pgb;
			pgr_s2  <= pgr;
			pb_s2   <= pb;
		end
	end

	// stage 3: round, add, clamp, pack
	always_comb begin
		rd  = jmcu_pkg::round_delta(pr_s2);
		gdb = jmcu_pkg::round_delta(pgb_s2);
		gdr = jmcu_pkg::round_delta(pgr_s2);
		bd  = jmcu_pkg::round_delta(pb_s2);
		gd  = 12'(gdb) + 12'(gdr);
		rs  = 18'(y_s2) + 18'(rd);
		gs  = 18'(y_s2) + 18'(gd);
		bs  = 18'(y_s2) + 18'(bd);
		r8  = jmcu_pkg::clamp8(rs);
		g8  = jmcu_pkg::clamp8(gs);
		b8  = jmcu_pkg::clamp8(bs);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_q <= {r8[7:3], g8[7:2], b8[7:3]};
			off_q   <= off_s2;
			last_q  <= last_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel       = pixel_q;
	assign word_offset = off_q;
	assign last        = last_q;

endmodule

// ----- rtl/core/jpeg_mcu_ycbcr_to_rgb565_core.sv -----
// ----------------------------------------------------------------------------
// jpeg_mcu_ycbcr_to_rgb565_core
// MCU color converter: YCbCr blocks to RGB565 rows with chroma upsampling.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): a load item (kind 0) writes one sample
// into the MCU store; Y blocks 0-3, Cb 4, Cr 5, blocks 6-7 are
// dropped. A row item (kind 1) emits one MCU row as RGB565 pixels with their
// frame word offsets, last marking the final pixel; rows outside the mode
// and zero sampling factors emit nothing.
// A row is accepted, then one pixel (of 8 or 16) is issued per cycle while
// the output does not stall, set by the single read port of each sample
// store; the next item is taken as soon as the last column is issued. Each
// pixel is registered after store read, chroma multiply and clamp/pack.
// Output channel (out_valid/out_ready): a stall freezes the whole pipeline
// and the column sequencer, nothing is dropped.
// Config channel (cfg_valid/cfg_ready): always ready; index 0 h_sampling,
// 1 v_sampling, 2 line_stride; write only while idle.
// Reset restores config defaults (2, 2, 16) and clears control state; the
// sample store is undefined until written, with no clearing pass.
module jpeg_mcu_ycbcr_to_rgb565_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [2:0]         block_select,
	input  logic [5:0]         sample_index,
	input  logic signed [15:0] sample_value,
	input  logic [3:0]         row_select,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        pixel,
	output logic [15:0]        word_offset,
	output logic               last
);

	jmcu_pkg::cmd_t  cmd;
	jmcu_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	jmcu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.stat     (stat),
		.cmd      (cmd)
	);

	jmcu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.block_select (block_select),
		.sample_index (sample_index),
		.sample_value (sample_value),
		.row_select   (row_select),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel        (pixel),
		.word_offset  (word_offset),
		.last         (last)
	);

endmodule
